@@ design/vat_pkg.sv @@
package vat_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned RegW    = 2 * CoefW;
  localparam int unsigned ProdW   = 2 * CoefW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RndW    = AccW - FracW;

  localparam logic [CfgIdxW-1:0] REG_COEF_R0C0_R1C0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_R2C0_R0C1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_R1C1_R2C1 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_R0C2_R1C2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COEF_R2C2_R0C3 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COEF_R1C3_R2C3 = 3'd5;

  localparam logic [RegW-1:0] RstDiag = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] RstZero = 64'h0000_0000_0000_0000;

  localparam logic signed [CoefW-1:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [CoefW-1:0] MinVal = 32'sh8000_0000;

  typedef struct packed {
    logic en2;
    logic en3;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [CoefW-1:0] val;
    logic                    sat;
  } sat_res_t;

  function automatic sat_res_t sat32(input logic signed [RndW-1:0] v);
    sat_res_t r;
    if (v > RndW'(MaxVal)) begin
      r.val = MaxVal;
      r.sat = 1'b1;
    end else if (v < RndW'(MinVal)) begin
      r.val = MinVal;
      r.sat = 1'b1;
    end else begin
      r.val = v[CoefW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ design/vat_row.sv @@
module vat_row (
  input  logic                                   clk_i,
  input  vat_pkg::pipe_ctl_t                     ctl_i,
  input  logic signed [vat_pkg::CoefW-1:0]       x_i,
  input  logic signed [vat_pkg::CoefW-1:0]       y_i,
  input  logic signed [vat_pkg::CoefW-1:0]       z_i,
  input  logic signed [vat_pkg::CoefW-1:0]       ca_i,
  input  logic signed [vat_pkg::CoefW-1:0]       cb_i,
  input  logic signed [vat_pkg::CoefW-1:0]       cc_i,
  input  logic signed [vat_pkg::CoefW-1:0]       ct_i,
  output logic signed [vat_pkg::RndW-1:0]        sum_o
);

  logic signed [vat_pkg::ProdW-1:0] px_q, py_q, pz_q;
  logic signed [vat_pkg::AccW-1:0]  acc_d;
  logic signed [vat_pkg::AccW-1:0]  trans;
  logic signed [vat_pkg::RndW-1:0]  sum_q;

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      px_q <= x_i * ca_i;
      py_q <= y_i * cb_i;
      pz_q <= z_i * cc_i;
    end
  end

  // translation in Q32.32 plus half an output lsb
  assign trans = (vat_pkg::AccW'(ct_i) <<< vat_pkg::FracW)
               + vat_pkg::AccW'(32'sd32768);

  assign acc_d = vat_pkg::AccW'(px_q) + vat_pkg::AccW'(py_q)
               + vat_pkg::AccW'(pz_q) + trans;

  // stage 3: sum and round
  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      sum_q <= acc_d[vat_pkg::AccW-1:vat_pkg::FracW];
    end
  end

  assign sum_o = sum_q;

endmodule

@@ design/vertex_affine_transform.sv @@
// Transforms a stream of Q16.16 vertices by the affine part of a column-major
// 4x4 matrix (w = 1), rounding half up and saturating each of x, y, z to 32
// bits; saturated_o flags any clipped component. The pipeline has four
// register stages (input, 32x32 multipliers, sum and round, saturate and
// output), and one item is taken every cycle while out_stall_i stays low.
// Bubbles are squeezed out on a stall. The six coefficient registers reset
// to the identity matrix; cfg_ready_o is always high and writes to indexes
// 6 and 7 are dropped.
// Write configuration only while no item is in flight.
module vertex_affine_transform (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  input  logic                               last_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 out_x_o,
  output logic signed [31:0]                 out_y_o,
  output logic signed [31:0]                 out_z_o,
  output logic                               last_out_o,
  output logic                               saturated_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vat_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vat_pkg::RegW-1:0]           cfg_data_i
);

  localparam int unsigned CW = vat_pkg::CoefW;

  logic [vat_pkg::RegW-1:0] reg_q [vat_pkg::NumRegs];

  logic en1, en2, en3, en_out;
  logic v1_q, v2_q, v3_q, out_v_q;
  logic l1_q, l2_q, l3_q, lo_q;
  logic signed [CW-1:0] x1_q, y1_q, z1_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q;
  logic sat_q;
  vat_pkg::pipe_ctl_t ctl;
  logic signed [vat_pkg::RndW-1:0] sum_x, sum_y, sum_z;
  vat_pkg::sat_res_t rx, ry, rz;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[0] <= vat_pkg::RstDiag;
      reg_q[1] <= vat_pkg::RstZero;
      reg_q[2] <= vat_pkg::RstDiag;
      reg_q[3] <= vat_pkg::RstZero;
      reg_q[4] <= vat_pkg::RstDiag;
      reg_q[5] <= vat_pkg::RstZero;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vat_pkg::REG_COEF_R0C0_R1C0: reg_q[0] <= cfg_data_i;
        vat_pkg::REG_COEF_R2C0_R0C1: reg_q[1] <= cfg_data_i;
        vat_pkg::REG_COEF_R1C1_R2C1: reg_q[2] <= cfg_data_i;
        vat_pkg::REG_COEF_R0C2_R1C2: reg_q[3] <= cfg_data_i;
        vat_pkg::REG_COEF_R2C2_R0C3: reg_q[4] <= cfg_data_i;
        vat_pkg::REG_COEF_R1C3_R2C3: reg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-stage enables: a stage moves when empty or when its successor moves
  assign en_out     = !out_v_q || !out_stall_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign ctl.en2    = en2;
  assign ctl.en3    = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= in_valid_i;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en_out) out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= pos_x_i;
      y1_q <= pos_y_i;
      z1_q <= pos_z_i;
      l1_q <= last_in_i;
    end
    if (en2) l2_q <= l1_q;
    if (en3) l3_q <= l2_q;
    if (en_out) begin
      ox_q  <= rx.val;
      oy_q  <= ry.val;
      oz_q  <= rz.val;
      lo_q  <= l3_q;
      sat_q <= rx.sat | ry.sat | rz.sat;
    end
  end

  vat_row u_row_x (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .x_i   (x1_q),
    .y_i   (y1_q),
    .z_i   (z1_q),
    .ca_i  (reg_q[0][CW-1:0]),
    .cb_i  (reg_q[1][2*CW-1:CW]),
    .cc_i  (reg_q[3][CW-1:0]),
    .ct_i  (reg_q[4][2*CW-1:CW]),
    .sum_o (sum_x)
  );

  vat_row u_row_y (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .x_i   (x1_q),
    .y_i   (y1_q),
    .z_i   (z1_q),
    .ca_i  (reg_q[0][2*CW-1:CW]),
    .cb_i  (reg_q[2][CW-1:0]),
    .cc_i  (reg_q[3][2*CW-1:CW]),
    .ct_i  (reg_q[5][CW-1:0]),
    .sum_o (sum_y)
  );

  vat_row u_row_z (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .x_i   (x1_q),
    .y_i   (y1_q),
    .z_i   (z1_q),
    .ca_i  (reg_q[1][CW-1:0]),
    .cb_i  (reg_q[2][2*CW-1:CW]),
    .cc_i  (reg_q[4][CW-1:0]),
    .ct_i  (reg_q[5][2*CW-1:CW]),
    .sum_o (sum_z)
  );

  assign rx = vat_pkg::sat32(sum_x);
  assign ry = vat_pkg::sat32(sum_y);
  assign rz = vat_pkg::sat32(sum_z);

  assign out_valid_o = out_v_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign last_out_o  = lo_q;
  assign saturated_o = sat_q;

endmodule

@@ design/vat_checker.sv @@
module vat_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic signed [31:0] out_z_o,
  input logic               last_out_o,
  input logic               saturated_o,
  input logic               cfg_ready_o
);

  // output item holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(last_out_o) && $stable(saturated_o))
    else $error("stalled output item changed");

  // an accepted item comes out after the pipeline depth when nothing stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // a clipped item has a component at a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_x_o == 32'sh7FFF_FFFF || out_x_o == 32'sh8000_0000 ||
      out_y_o == 32'sh7FFF_FFFF || out_y_o == 32'sh8000_0000 ||
      out_z_o == 32'sh7FFF_FFFF || out_z_o == 32'sh8000_0000)
    else $error("saturated set without a clipped component");

  // input side is never held, and cfg_ready_o is high, while the output stage is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o && cfg_ready_o)
    else $error("input stalled with empty output stage");

endmodule

bind vertex_affine_transform vat_checker u_vat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .last_out_o  (last_out_o),
  .saturated_o (saturated_o),
  .cfg_ready_o (cfg_ready_o)
);
